@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the grid gradient RTL.
// Expects clk_i and rst_ni in the scope of the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

@@ rtl/core/ggbm_pkg.sv @@
// Shared constants, types and helpers for the grid gradient basis map.
// No dependencies; imported by every module of the block.
`default_nettype none

package ggbm_pkg;

  // Sizing
  localparam int MAX_SIDE  = 1024;
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 16;
  localparam int GRID_W    = 11;
  localparam int GRAD_W    = 45;
  localparam int OUT_IDX_W = 10;
  localparam int IDX_W     = $clog2(MAX_SIDE);
  localparam int SIDE_W    = $clog2(MAX_SIDE + 1);
  localparam int DEPTH     = 3 * MAX_SIDE;
  localparam int ADDR_W    = $clog2(DEPTH);

  // Datapath widths: half-unit difference, scaled derivative, basis product
  localparam int DH_W   = SAMPLE_W + 2;
  localparam int DER_W  = DH_W + SIDE_W + 1;
  localparam int PROD_W = DER_W + COEF_W;

  // Stream payload widths
  localparam int IN_DATA_W  = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_RAW_W  = 2 * GRAD_W + 2 * OUT_IDX_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = (GRID_W > COEF_W) ? GRID_W : COEF_W;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_B00       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B01       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B10       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B11       = 3'd4;

  localparam logic [GRID_W-1:0]        GRID_RST = GRID_W'(1024);
  localparam logic signed [COEF_W-1:0] B00_RST  = COEF_W'(16384);
  localparam logic signed [COEF_W-1:0] B01_RST  = '0;
  localparam logic signed [COEF_W-1:0] B10_RST  = '0;
  localparam logic signed [COEF_W-1:0] B11_RST  = COEF_W'(16384);

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OFFER = 4'b1000
  } ggbm_state_e;

  // Basis matrix, Q1.14
  typedef struct packed {
    logic signed [COEF_W-1:0] c00;
    logic signed [COEF_W-1:0] c01;
    logic signed [COEF_W-1:0] c10;
    logic signed [COEF_W-1:0] c11;
  } ggbm_basis_t;

  // Line store access from the sequencer
  typedef struct packed {
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    logic [SAMPLE_W-1:0] wdata;
    logic                re;
    logic [ADDR_W-1:0]   raddr;
  } ggbm_mem_req_t;

  // Point tag carried alongside the arithmetic
  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } ggbm_meta_t;

  // One result to compute: neighbors (edge ones replaced by the center)
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] up;
    logic signed [SAMPLE_W-1:0] dn;
    logic signed [SAMPLE_W-1:0] lf;
    logic signed [SAMPLE_W-1:0] rt;
    logic                       row_edge;
    logic                       col_edge;
    ggbm_meta_t                 meta;
  } ggbm_job_t;

  // Row slot arithmetic modulo 3
  function automatic logic [1:0] slot_dec(input logic [1:0] s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [1:0] slot_inc(input logic [1:0] s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] line_addr(input logic [1:0] slot,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(slot) * ADDR_W'(MAX_SIDE) + ADDR_W'(col);
  endfunction

  // Side in use: grid size clamped to [2, MAX_SIDE]
  function automatic logic [SIDE_W-1:0] clamp_side(input logic [GRID_W-1:0] gs);
    logic [SIDE_W-1:0] res;
    if (gs < GRID_W'(2)) begin
      res = SIDE_W'(2);
    end else if (32'(gs) > MAX_SIDE) begin
      res = SIDE_W'(MAX_SIDE);
    end else begin
      res = SIDE_W'(gs);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/grid_gradient_basis_map.sv @@
// Top level of the grid gradient basis map: configuration registers and
// the sequencer, line store and arithmetic pipeline. Depends on ggbm_pkg.
//
//  channel   direction  handshake                 payload
//  s_axis    in         tvalid / tready           tdata[15:0] sample
//  m_axis    out        tvalid / tready           tdata grads, row, column; tlast
//  cfg       in         cfg_we_i (no back-press)  cfg_idx_i, cfg_data_i
//
// An item on the first row of a frame is only written to the line store. Every
// other item holds off the input until each result it causes (1, 2 or 3
// results) is gathered and taken: each result needs four neighbor reads through
// the single read port of the line store. Results then pass the arithmetic
// pipeline to the output register; a stalled output halts the pipe.
// Reset clears control only; the line store needs no clearing pass, since
// every read hits an entry written earlier in the same frame.
`default_nettype none

module grid_gradient_basis_map
  import ggbm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] sample
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [44:0] grad_first, [89:45] grad_second, [99:90] out_row, [109:100] out_column
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,   // run_last
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [GRID_W-1:0] grid_size_q;
  ggbm_basis_t       basis_q;
  logic [SIDE_W-1:0] side;
  logic              restart;

  ggbm_mem_req_t       mem_req;
  logic [SAMPLE_W-1:0] mem_rdata;
  ggbm_job_t           job;
  logic                job_valid, job_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_RST;
      basis_q.c00 <= B00_RST;
      basis_q.c01 <= B01_RST;
      basis_q.c10 <= B10_RST;
      basis_q.c11 <= B11_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_SIZE: grid_size_q <= cfg_data_i[GRID_W-1:0];
        REG_B00:       basis_q.c00 <= $signed(cfg_data_i[COEF_W-1:0]);
        REG_B01:       basis_q.c01 <= $signed(cfg_data_i[COEF_W-1:0]);
        REG_B10:       basis_q.c10 <= $signed(cfg_data_i[COEF_W-1:0]);
        REG_B11:       basis_q.c11 <= $signed(cfg_data_i[COEF_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  assign side    = clamp_side(grid_size_q);
  assign restart = cfg_we_i && (cfg_idx_i == REG_GRID_SIZE);

  ggbm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .side_i        (side),
    .restart_i     (restart),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata),
    .job_o         (job),
    .job_valid_o   (job_valid),
    .job_ready_i   (job_ready)
  );

  ggbm_line_store u_line_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  ggbm_calc u_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .side_i        (side),
    .basis_i       (basis_q),
    .job_i         (job),
    .job_valid_i   (job_valid),
    .job_ready_o   (job_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ rtl/core/ggbm_line_store.sv @@
// Line store: three rows of samples, one write and one registered read port.
// Depends on ggbm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ggbm_line_store
  import ggbm_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ggbm_mem_req_t       req_i,
  output logic [SAMPLE_W-1:0]      rdata_o
);

  logic [SAMPLE_W-1:0] mem_q [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  // Write first-come, read data registered
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

  `ASSERT_NEVER(a_rw_same_addr, req_i.we && req_i.re && (req_i.waddr == req_i.raddr), "line store read and write collide")
  `ASSERT_CLK(a_raddr_range, req_i.re |-> (32'(req_i.raddr) < DEPTH), "line store read out of range")

endmodule

`default_nettype wire

@@ rtl/core/ggbm_seq.sv @@
// Sequencer: raster counters, line store writes, neighbor reads per result.
// Depends on ggbm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ggbm_seq
  import ggbm_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [SIDE_W-1:0]    side_i,
  input  wire logic                 restart_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [IN_DATA_W-1:0] s_axis_tdata,  // [15:0] sample
  output ggbm_mem_req_t             mem_req_o,
  input  wire logic [SAMPLE_W-1:0]  mem_rdata_i,
  output ggbm_job_t                 job_o,
  output logic                      job_valid_o,
  input  wire logic                 job_ready_i
);

  // Results an item can cause, in emission order
  localparam logic [1:0] JOB_ABOVE = 2'd0;  // point one row up
  localparam logic [1:0] JOB_LEFT  = 2'd1;  // last row, point to the left
  localparam logic [1:0] JOB_HERE  = 2'd2;  // last sample of the frame

  // Neighbor read order
  localparam logic [1:0] RD_UP = 2'd0;
  localparam logic [1:0] RD_DN = 2'd1;
  localparam logic [1:0] RD_LF = 2'd2;
  localparam logic [1:0] RD_RT = 2'd3;

  ggbm_state_e state_q, state_d;

  logic [IDX_W-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]       slot_q, slot_d;
  logic [IDX_W-1:0] cur_r_q, cur_r_d, cur_c_q, cur_c_d;
  logic [1:0]       cur_slot_q, cur_slot_d;
  logic             en_left_q, en_left_d, en_here_q, en_here_d;
  logic [1:0]       job_q, job_d;
  logic [1:0]       rd_k_q, rd_k_d;
  logic             rd_v_q;
  logic [1:0]       rd_k_prev_q;

  logic signed [SAMPLE_W-1:0] up_q, dn_q, lf_q, rt_q;

  logic [IDX_W-1:0] side_m1;
  logic             in_range;
  logic [IDX_W-1:0] r_eff, c_eff;
  logic [1:0]       slot_eff;
  logic             col_last, row_last;
  logic             accept;

  logic [IDX_W-1:0]  pa, pb;
  logic [1:0]        slot_a;
  logic              row_top, row_bot, col_lf, col_rt;
  logic [ADDR_W-1:0] here_addr, raddr;
  logic              job_last;

  // Current position, forced to the frame start if it lies outside the side
  always_comb begin
    side_m1  = IDX_W'(side_i - 1'b1);
    in_range = (row_q <= side_m1) && (col_q <= side_m1);
    r_eff    = in_range ? row_q : '0;
    c_eff    = in_range ? col_q : '0;
    slot_eff = in_range ? slot_q : 2'd0;
    col_last = (c_eff == side_m1);
    row_last = (r_eff == side_m1);
    accept   = s_axis_tvalid && (state_q == S_IDLE);
  end

  assign s_axis_tready = (state_q == S_IDLE);

  // Point of the result being gathered
  always_comb begin
    unique case (job_q)
      JOB_ABOVE: begin
        pa     = cur_r_q - IDX_W'(1);
        slot_a = slot_dec(cur_slot_q);
        pb     = cur_c_q;
      end
      JOB_LEFT: begin
        pa     = cur_r_q;
        slot_a = cur_slot_q;
        pb     = cur_c_q - IDX_W'(1);
      end
      default: begin
        pa     = cur_r_q;
        slot_a = cur_slot_q;
        pb     = cur_c_q;
      end
    endcase
    row_top   = (pa == '0);
    row_bot   = (pa == side_m1);
    col_lf    = (pb == '0);
    col_rt    = (pb == side_m1);
    here_addr = line_addr(slot_a, pb);
    job_last  = (job_q == JOB_HERE) ||
                ((job_q == JOB_LEFT) && !en_here_q) ||
                ((job_q == JOB_ABOVE) && !en_left_q);
  end

  // Neighbor address; a missing neighbor reads the center point
  always_comb begin
    unique case (rd_k_q)
      RD_UP:   raddr = row_top ? here_addr : line_addr(slot_dec(slot_a), pb);
      RD_DN:   raddr = row_bot ? here_addr : line_addr(slot_inc(slot_a), pb);
      RD_LF:   raddr = col_lf  ? here_addr : line_addr(slot_a, pb - IDX_W'(1));
      default: raddr = col_rt  ? here_addr : line_addr(slot_a, pb + IDX_W'(1));
    endcase
  end

  always_comb begin
    mem_req_o.we    = accept;
    mem_req_o.waddr = line_addr(slot_eff, c_eff);
    mem_req_o.wdata = s_axis_tdata[SAMPLE_W-1:0];
    mem_req_o.re    = (state_q == S_READ);
    mem_req_o.raddr = raddr;
  end

  // Control: counters and the per-item sequence
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    slot_d     = slot_q;
    cur_r_d    = cur_r_q;
    cur_c_d    = cur_c_q;
    cur_slot_d = cur_slot_q;
    en_left_d  = en_left_q;
    en_here_d  = en_here_q;
    job_d      = job_q;
    rd_k_d     = rd_k_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cur_r_d    = r_eff;
          cur_c_d    = c_eff;
          cur_slot_d = slot_eff;
          en_left_d  = row_last && (c_eff != '0);
          en_here_d  = row_last && col_last;
          job_d      = JOB_ABOVE;
          rd_k_d     = RD_UP;
          if (col_last) begin
            col_d = '0;
            if (row_last) begin
              row_d  = '0;
              slot_d = 2'd0;
            end else begin
              row_d  = r_eff + IDX_W'(1);
              slot_d = slot_inc(slot_eff);
            end
          end else begin
            row_d  = r_eff;
            col_d  = c_eff + IDX_W'(1);
            slot_d = slot_eff;
          end
          if (r_eff != '0) begin
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        rd_k_d = rd_k_q + 2'd1;
        if (rd_k_q == RD_RT) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        state_d = S_OFFER;
      end
      S_OFFER: begin
        if (job_ready_i) begin
          if (job_last) begin
            state_d = S_IDLE;
          end else begin
            job_d   = job_q + 2'd1;
            rd_k_d  = RD_UP;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Grid size write restarts the frame
    if (restart_i) begin
      row_d  = '0;
      col_d  = '0;
      slot_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      slot_q      <= 2'd0;
      cur_r_q     <= '0;
      cur_c_q     <= '0;
      cur_slot_q  <= 2'd0;
      en_left_q   <= 1'b0;
      en_here_q   <= 1'b0;
      job_q       <= JOB_ABOVE;
      rd_k_q      <= RD_UP;
      rd_v_q      <= 1'b0;
      rd_k_prev_q <= RD_UP;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      slot_q      <= slot_d;
      cur_r_q     <= cur_r_d;
      cur_c_q     <= cur_c_d;
      cur_slot_q  <= cur_slot_d;
      en_left_q   <= en_left_d;
      en_here_q   <= en_here_d;
      job_q       <= job_d;
      rd_k_q      <= rd_k_d;
      rd_v_q      <= (state_q == S_READ);
      rd_k_prev_q <= rd_k_q;
    end
  end

  // Capture read data in the cycle after each read, from the registered read port
  always_ff @(posedge clk_i) begin
    if (rd_v_q) begin
      unique case (rd_k_prev_q)
        RD_UP:   up_q <= $signed(mem_rdata_i);
        RD_DN:   dn_q <= $signed(mem_rdata_i);
        RD_LF:   lf_q <= $signed(mem_rdata_i);
        default: rt_q <= $signed(mem_rdata_i);
      endcase
    end
  end

  always_comb begin
    job_o.up        = up_q;
    job_o.dn        = dn_q;
    job_o.lf        = lf_q;
    job_o.rt        = rt_q;
    job_o.row_edge  = row_top || row_bot;
    job_o.col_edge  = col_lf || col_rt;
    job_o.meta.row  = pa;
    job_o.meta.col  = pb;
    job_o.meta.last = job_last;
  end

  assign job_valid_o = (state_q == S_OFFER);

  `ASSERT_CLK(a_busy_no_accept, job_valid_o |-> !s_axis_tready, "input ready while a result is pending")
  `ASSERT_CLK(a_col_in_side, (col_q <= side_m1) && (row_q <= side_m1), "raster counter beyond side")
  `ASSERT_CLK(a_read_then_wait, (state_q == S_READ) && (rd_k_q == RD_RT) |=> (state_q == S_WAIT), "read sequence overran")

endmodule

`default_nettype wire

@@ rtl/core/ggbm_calc.sv @@
// Gradient arithmetic: differences, scaling by the side, basis mapping.
// Depends on ggbm_pkg and assert_macros.svh; ends in the output register.
`default_nettype none
`include "assert_macros.svh"

module ggbm_calc
  import ggbm_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [SIDE_W-1:0]     side_i,
  input  wire ggbm_basis_t           basis_i,
  input  wire ggbm_job_t             job_i,
  input  wire logic                  job_valid_i,
  output logic                       job_ready_o,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // [44:0] grad_first, [89:45] grad_second, [99:90] out_row, [109:100] out_column
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast  // run_last
);

  logic en;
  logic v1_q, v2_q, v3_q, out_valid_q;

  logic signed [DH_W-1:0]   drh_q, dch_q, drh_d, dch_d;
  logic signed [DER_W-1:0]  dr_q, dc_q;
  logic signed [PROD_W-1:0] p00_q, p01_q, p10_q, p11_q;
  logic signed [GRAD_W-1:0] g1_q, g2_q;
  ggbm_meta_t               m1_q, m2_q, m3_q, mo_q;
  logic signed [DER_W-1:0]  side_s;

  // Whole pipeline moves when the output register is free or being taken
  assign en          = !out_valid_q || m_axis_tready;
  assign job_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= job_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // Half-unit differences, doubled on the one-sided edges
  always_comb begin
    drh_d = DH_W'(job_i.dn) - DH_W'(job_i.up);
    dch_d = DH_W'(job_i.rt) - DH_W'(job_i.lf);
    if (job_i.row_edge) begin
      drh_d = drh_d <<< 1;
    end
    if (job_i.col_edge) begin
      dch_d = dch_d <<< 1;
    end
  end

  assign side_s = $signed(DER_W'(side_i));

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: differences
      drh_q <= drh_d;
      dch_q <= dch_d;
      m1_q  <= job_i.meta;
      // stage 2: scale by the side
      dr_q  <= DER_W'(drh_q) * side_s;
      dc_q  <= DER_W'(dch_q) * side_s;
      m2_q  <= m1_q;
      // stage 3: basis products
      p00_q <= PROD_W'(dr_q) * PROD_W'(basis_i.c00);
      p01_q <= PROD_W'(dc_q) * PROD_W'(basis_i.c01);
      p10_q <= PROD_W'(dr_q) * PROD_W'(basis_i.c10);
      p11_q <= PROD_W'(dc_q) * PROD_W'(basis_i.c11);
      m3_q  <= m2_q;
      // stage 4: sums into the output register
      g1_q  <= GRAD_W'(p00_q + p01_q);
      g2_q  <= GRAD_W'(p10_q + p11_q);
      mo_q  <= m3_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({OUT_IDX_W'(mo_q.col), OUT_IDX_W'(mo_q.row), g2_q, g1_q});
  assign m_axis_tlast  = mo_q.last;

  `ASSERT_CLK(a_job_enters, (job_valid_i && en) |=> v1_q, "accepted job lost in stage one")

endmodule

`default_nettype wire
